// ===== sv/tilt_to_drive_command_mapper_macros.svh =====
// ----------------------------------------------------------------------------
// Tilt-to-drive mapper assertion macros
// Concurrent property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TILT_TO_DRIVE_COMMAND_MAPPER_MACROS_SVH
`define TILT_TO_DRIVE_COMMAND_MAPPER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TDCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdcm property violated");

// Next-cycle implication, disabled during reset
`define TDCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdcm property violated");

`endif

// ===== sv/tdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt-to-drive mapper package
// Widths, register codes, drive codes, controller state and control types.
// ----------------------------------------------------------------------------
package tdcm_pkg;

   localparam int ANGLE_W   = 17;
   localparam int MAG_W     = 17;
   localparam int CFG_W     = 16;
   localparam int TRIG_W    = 8;
   localparam int CMD_W     = 2;
   localparam int SPEED_W   = 10;
   localparam int STEER_W   = 8;
   localparam int CSR_IDX_W = 3;

   // Divider: magnitude span times full output, quotient kept to DIV_Q_W bits
   localparam int DIV_Q_W = 11;
   localparam int NUM_W   = MAG_W + SPEED_W;
   localparam int REM_W   = NUM_W - DIV_Q_W;
   localparam int STEP_W  = $clog2(DIV_Q_W);

   localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd999;
   localparam logic [SPEED_W-1:0] STEER_MAX = 10'd100;
   localparam logic [TRIG_W-1:0]  RUN_MAX   = 8'd255;

   localparam logic [CFG_W-1:0]  RST_BRAKE_BACK_ANGLE = 16'd15360;
   localparam logic [CFG_W-1:0]  RST_UNLOCK_PITCH     = 16'd3840;
   localparam logic [CFG_W-1:0]  RST_PITCH_DEAD_ZONE  = 16'd2560;
   localparam logic [CFG_W-1:0]  RST_PITCH_FULL_SCALE = 16'd11520;
   localparam logic [CFG_W-1:0]  RST_ROLL_DEAD_ZONE   = 16'd2560;
   localparam logic [CFG_W-1:0]  RST_ROLL_FULL_SCALE  = 16'd11520;
   localparam logic [TRIG_W-1:0] BRAKE_TRIGGER_CNT    = 8'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRAKE_BACK_ANGLE = 3'd0,
      CSR_UNLOCK_PITCH     = 3'd1,
      CSR_PITCH_DEAD_ZONE  = 3'd2,
      CSR_PITCH_FULL_SCALE = 3'd3,
      CSR_ROLL_DEAD_ZONE   = 3'd4,
      CSR_ROLL_FULL_SCALE  = 3'd5,
      CSR_BRAKE_TRIGGER    = 3'd6
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      DRV_STOP     = 2'd0,
      DRV_FORWARD  = 2'd1,
      DRV_BACKWARD = 2'd2,
      DRV_BRAKE    = 2'd3
   } drive_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PITCH_MUL,
      ST_PITCH_LOAD,
      ST_PITCH_DIV,
      ST_PITCH_SAVE,
      ST_ROLL_MUL,
      ST_ROLL_LOAD,
      ST_ROLL_DIV,
      ST_ROLL_SAVE,
      ST_EMIT
   } tdcm_state_type;

   typedef struct packed {
      logic load_in;
      logic check;
      logic mul_en;
      logic div_load;
      logic div_step;
      logic save_en;
      logic sel_roll;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic brake;
      logic skip;
      logic out_busy;
   } ctrl_status_type;

endpackage

// ===== sv/tdcm_datapath.sv =====
// ----------------------------------------------------------------------------
// Tilt-to-drive mapper datapath
// Registers, brake latch, shared multiplier and restoring divider, result
// staging and the output register.
// ----------------------------------------------------------------------------
module tdcm_datapath import tdcm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_cmd_type                ctrl,
   output ctrl_status_type             status,
   input  logic signed [ANGLE_W-1:0]   req_pitch_angle,
   input  logic signed [ANGLE_W-1:0]   req_roll_angle,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [CMD_W-1:0]            rsp_drive_command,
   output logic [SPEED_W-1:0]          rsp_speed,
   output logic signed [STEER_W-1:0]   rsp_steer
);

   logic [CFG_W-1:0]  bba_ff, unlock_ff, pdz_ff, pfs_ff, rdz_ff, rfs_ff;
   logic [TRIG_W-1:0] trig_ff;

   logic [ANGLE_W-1:0] pitch_ff, roll_ff;
   logic [MAG_W-1:0]   pmag, rmag;

   logic               locked_ff, locked_in;
   logic [TRIG_W-1:0]  run_ff, run_in, run_inc;
   logic               back, lock_now, unlock, brake;

   logic [MAG_W-1:0]   mag, diff;
   logic [CFG_W-1:0]   dz, full;
   logic [SPEED_W-1:0] top;
   logic               below_dz;
   logic [NUM_W-1:0]   prod;

   logic [NUM_W-1:0]   num_ff;
   logic [CFG_W-1:0]   den_ff;
   logic               fixed_ff, below_ff, sat_ff;
   logic [SPEED_W-1:0] fixed_val_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [DIV_Q_W-1:0] quot_ff;
   logic [REM_W:0]     trial;
   logic               trial_ge;
   logic               sat_now;
   logic [SPEED_W-1:0] val;

   drive_cmd_type      res_cmd_ff, pitch_cmd;
   logic [SPEED_W-1:0] res_speed_ff;
   logic [STEER_W-1:0] res_steer_ff, steer_bits;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]   rsp_cmd_ff;
   logic [SPEED_W-1:0] rsp_speed_ff;
   logic [STEER_W-1:0] rsp_steer_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bba_ff    <= RST_BRAKE_BACK_ANGLE;
         unlock_ff <= RST_UNLOCK_PITCH;
         pdz_ff    <= RST_PITCH_DEAD_ZONE;
         pfs_ff    <= RST_PITCH_FULL_SCALE;
         rdz_ff    <= RST_ROLL_DEAD_ZONE;
         rfs_ff    <= RST_ROLL_FULL_SCALE;
         trig_ff   <= BRAKE_TRIGGER_CNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BRAKE_BACK_ANGLE: bba_ff    <= csr_wdata;
            CSR_UNLOCK_PITCH:     unlock_ff <= csr_wdata;
            CSR_PITCH_DEAD_ZONE:  pdz_ff    <= csr_wdata;
            CSR_PITCH_FULL_SCALE: pfs_ff    <= csr_wdata;
            CSR_ROLL_DEAD_ZONE:   rdz_ff    <= csr_wdata;
            CSR_ROLL_FULL_SCALE:  rfs_ff    <= csr_wdata;
            CSR_BRAKE_TRIGGER:    trig_ff   <= csr_wdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_in) begin
         pitch_ff <= req_pitch_angle;
         roll_ff  <= req_roll_angle;
      end
   end

   assign pmag = pitch_ff[ANGLE_W-1] ? (~pitch_ff + MAG_W'(1)) : pitch_ff;
   assign rmag = roll_ff[ANGLE_W-1]  ? (~roll_ff + MAG_W'(1))  : roll_ff;

   // Brake latch: backward pitch means negative and beyond the brake angle
   always_comb begin
      back     = pitch_ff[ANGLE_W-1] && (pmag > {1'b0, bba_ff});
      run_inc  = '0;
      if (back) begin
         run_inc = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + TRIG_W'(1);
      end
      lock_now = back && (run_inc >= trig_ff);
      unlock   = pmag < {1'b0, unlock_ff};
      brake    = lock_now || (locked_ff && !unlock);
      run_in   = lock_now ? '0 : run_inc;
      priority if (lock_now) begin
         locked_in = 1'b1;
      end else if (locked_ff && unlock) begin
         locked_in = 1'b0;
      end else begin
         locked_in = locked_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff <= 1'b0;
         run_ff    <= '0;
      end else if (ctrl.check) begin
         locked_ff <= locked_in;
         run_ff    <= run_in;
      end
   end

   // Operand select for the shared scaling unit
   always_comb begin
      mag      = ctrl.sel_roll ? rmag : pmag;
      dz       = ctrl.sel_roll ? rdz_ff : pdz_ff;
      full     = ctrl.sel_roll ? rfs_ff : pfs_ff;
      top      = ctrl.sel_roll ? STEER_MAX : SPEED_MAX;
      below_dz = mag < {1'b0, dz};
      diff     = mag - {1'b0, dz};
      prod     = NUM_W'(diff) * NUM_W'(top);
   end

   assign sat_now  = num_ff[NUM_W-1:DIV_Q_W] >= den_ff;
   assign trial    = {rem_ff, num_ff[DIV_Q_W-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         num_ff       <= prod;
         den_ff       <= full - dz;
         below_ff     <= below_dz;
         fixed_ff     <= below_dz || (full <= dz);
         fixed_val_ff <= below_dz ? '0 : top;
      end else if (ctrl.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
      end
      if (ctrl.div_load) begin
         rem_ff  <= num_ff[NUM_W-1:DIV_Q_W];
         sat_ff  <= sat_now;
         quot_ff <= '0;
      end else if (ctrl.div_step) begin
         rem_ff  <= trial_ge ? REM_W'(trial - {1'b0, den_ff}) : trial[REM_W-1:0];
         quot_ff <= {quot_ff[DIV_Q_W-2:0], trial_ge};
      end
   end

   // Truncated quotient, saturated at the output's full value
   always_comb begin
      priority if (fixed_ff) begin
         val = fixed_val_ff;
      end else if (sat_ff || (quot_ff > DIV_Q_W'(top))) begin
         val = top;
      end else begin
         val = quot_ff[SPEED_W-1:0];
      end
      priority if (below_ff) begin
         pitch_cmd = DRV_STOP;
      end else if (!pitch_ff[ANGLE_W-1] && (pitch_ff != '0)) begin
         pitch_cmd = DRV_FORWARD;
      end else begin
         pitch_cmd = DRV_BACKWARD;
      end
      // roll of zero takes the negative side
      if (!roll_ff[ANGLE_W-1] && (roll_ff != '0)) begin
         steer_bits = val[STEER_W-1:0];
      end else begin
         steer_bits = STEER_W'(0) - val[STEER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.check && brake) begin
         res_cmd_ff   <= DRV_BRAKE;
         res_speed_ff <= '0;
         res_steer_ff <= '0;
      end else if (ctrl.save_en && !ctrl.sel_roll) begin
         res_cmd_ff   <= pitch_cmd;
         res_speed_ff <= val;
      end else if (ctrl.save_en && ctrl.sel_roll) begin
         res_steer_ff <= steer_bits;
      end
   end

   // Output register: hold while stalled, drop valid once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_cmd_ff   <= res_cmd_ff;
         rsp_speed_ff <= res_speed_ff;
         rsp_steer_ff <= res_steer_ff;
      end
   end

   assign status.brake    = brake;
   assign status.skip     = fixed_ff || sat_now;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_command = rsp_cmd_ff;
   assign rsp_speed         = rsp_speed_ff;
   assign rsp_steer         = rsp_steer_ff;

endmodule

// ===== sv/tdcm_controller.sv =====
// ----------------------------------------------------------------------------
// Tilt-to-drive mapper controller
// Sequences brake check, pitch scaling, roll scaling and result transfer.
// ----------------------------------------------------------------------------
module tdcm_controller import tdcm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    ctrl
);

   tdcm_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              in_div, last_step;

   assign in_div    = (state_ff == ST_PITCH_DIV) || (state_ff == ST_ROLL_DIV);
   assign last_step = step_ff == STEP_W'(DIV_Q_W - 1);
   assign step_in   = (in_div && !last_step) ? step_ff + STEP_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_CHECK;
         ST_CHECK:      state_in = status.brake ? ST_EMIT : ST_PITCH_MUL;
         ST_PITCH_MUL:  state_in = ST_PITCH_LOAD;
         ST_PITCH_LOAD: state_in = status.skip ? ST_PITCH_SAVE : ST_PITCH_DIV;
         ST_PITCH_DIV:  if (last_step) state_in = ST_PITCH_SAVE;
         ST_PITCH_SAVE: state_in = ST_ROLL_MUL;
         ST_ROLL_MUL:   state_in = ST_ROLL_LOAD;
         ST_ROLL_LOAD:  state_in = status.skip ? ST_ROLL_SAVE : ST_ROLL_DIV;
         ST_ROLL_DIV:   if (last_step) state_in = ST_ROLL_SAVE;
         ST_ROLL_SAVE:  state_in = ST_EMIT;
         ST_EMIT:       if (!status.out_busy) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            ctrl.load_in = req_valid;
         end
         ST_CHECK:      ctrl.check = 1'b1;
         ST_PITCH_MUL:  ctrl.mul_en = 1'b1;
         ST_PITCH_LOAD: ctrl.div_load = 1'b1;
         ST_PITCH_DIV:  ctrl.div_step = 1'b1;
         ST_PITCH_SAVE: ctrl.save_en = 1'b1;
         ST_ROLL_MUL: begin
            ctrl.mul_en   = 1'b1;
            ctrl.sel_roll = 1'b1;
         end
         ST_ROLL_LOAD: begin
            ctrl.div_load = 1'b1;
            ctrl.sel_roll = 1'b1;
         end
         ST_ROLL_DIV: begin
            ctrl.div_step = 1'b1;
            ctrl.sel_roll = 1'b1;
         end
         ST_ROLL_SAVE: begin
            ctrl.save_en  = 1'b1;
            ctrl.sel_roll = 1'b1;
         end
         ST_EMIT:       ctrl.emit = !status.out_busy;
         default: ;
      endcase
   end

endmodule

// ===== sv/tilt_to_drive_command_mapper.sv =====
// ----------------------------------------------------------------------------
// Tilt-to-drive command mapper
// A brake result goes straight to emit; otherwise pitch and roll each run an 11-step shared-divider pass.
// Each dead zone, full-scale or saturated output skips its 11-step pass.
// One item in flight; next accepted the cycle after the result is loaded.
// Synchronous reset restores register defaults and clears latch and counter.
// ----------------------------------------------------------------------------
module tilt_to_drive_command_mapper import tdcm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ANGLE_W-1:0]   req_pitch_angle,
   input  logic signed [ANGLE_W-1:0]   req_roll_angle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [CMD_W-1:0]            rsp_drive_command,
   output logic [SPEED_W-1:0]          rsp_speed,
   output logic signed [STEER_W-1:0]   rsp_steer,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata
);

   ctrl_cmd_type    ctrl;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   tdcm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   tdcm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_pitch_angle   (req_pitch_angle),
      .req_roll_angle    (req_roll_angle),
      .csr_we            (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_drive_command (rsp_drive_command),
      .rsp_speed         (rsp_speed),
      .rsp_steer         (rsp_steer)
   );

endmodule

// ===== sv/tdcm_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt-to-drive mapper checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tilt_to_drive_command_mapper_macros.svh"

module tdcm_checker import tdcm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [CMD_W-1:0]          rsp_drive_command,
   input logic [SPEED_W-1:0]        rsp_speed,
   input logic signed [STEER_W-1:0] rsp_steer
);

   // a stalled transfer keeps its payload
   `TDCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive_command) && $stable(rsp_speed) && $stable(rsp_steer))

   `TDCM_ASSERT_IMPLY(a_brake_zero, clock, reset, rsp_valid && (rsp_drive_command == DRV_BRAKE), (rsp_speed == '0) && (rsp_steer == '0))

   `TDCM_ASSERT_IMPLY(a_stop_zero, clock, reset, rsp_valid && (rsp_drive_command == DRV_STOP), rsp_speed == '0)

   `TDCM_ASSERT_IMPLY(a_speed_range, clock, reset, rsp_valid, rsp_speed <= SPEED_MAX)

   `TDCM_ASSERT_IMPLY(a_steer_range, clock, reset, rsp_valid, (rsp_steer >= -8'sd100) && (rsp_steer <= 8'sd100))

endmodule

bind tilt_to_drive_command_mapper tdcm_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_drive_command (rsp_drive_command),
   .rsp_speed         (rsp_speed),
   .rsp_steer         (rsp_steer)
);
